// ===== rtl/core/tfht_pkg.sv =====
// shared types and constants for the triplet frequency hash table
package tfht_pkg;

    localparam int unsigned IN_W  = 96;
    localparam int unsigned OUT_W = 80;

    typedef enum logic [1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        KIND_HIT,
        KIND_FOUND,
        KIND_FILL,
        KIND_EVICT,
        KIND_MISS,
        KIND_FULL
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  mod_step;
        logic  probe_init;
        logic  probe_rd;
        logic  probe_next;
        logic  scan_begin;
        logic  scan_run;
        logic  clr_wr;
        logic  commit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic  mod_done;
        logic  q_hit;
        logic  q_empty;
        logic  probe_last;
        logic  scan_done;
        logic  clr_last;
        logic  out_free;
        t_func func;
    } t_sts;

endpackage

// ===== rtl/core/tfht_ctrl.sv =====
// controller state machine for the triplet frequency hash table
module tfht_ctrl
    import tfht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_func i_func,
    input  t_sts  i_sts,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_func == FUNC_NONE) begin
                        n_kind  = KIND_MISS;
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.q_hit) begin
                    n_kind  = (i_sts.func == FUNC_LOOKUP) ? KIND_FOUND : KIND_HIT;
                    n_state = S_COMMIT;
                end else if (i_sts.q_empty) begin
                    n_kind  = (i_sts.func == FUNC_LOOKUP) ? KIND_MISS : KIND_FILL;
                    n_state = S_COMMIT;
                end else if (i_sts.probe_last) begin
                    case (i_sts.func)
                        FUNC_RECORD: begin
                            o_cmd.scan_begin = 1'b1;
                            n_state = S_SCAN;
                        end
                        FUNC_ADD: begin
                            n_kind  = KIND_FULL;
                            n_state = S_COMMIT;
                        end
                        default: begin
                            n_kind  = KIND_MISS;
                            n_state = S_COMMIT;
                        end
                    endcase
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state = S_RD;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_kind  = KIND_EVICT;
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_kind  <= KIND_MISS;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/core/tfht_dp.sv =====
// datapath of the triplet frequency hash table: hash, slot memory, scan and result register
module tfht_dp
    import tfht_pkg::*;
#(
    parameter int unsigned CAPACITY  = 256,
    parameter int unsigned NODE_BITS = 16,
    parameter int unsigned TAG_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_tdata,
    input  logic             i_out_ready,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int unsigned IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned KW      = TAG_BITS + 3 * NODE_BITS;
    localparam int unsigned MW      = 1 + KW + 64;
    localparam bit          IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] r_q;

    t_func            r_func;
    logic [KW-1:0]    r_key;
    logic [31:0]      r_amt;
    logic [31:0]      r_h;
    logic [IW-1:0]    r_rem;
    logic [5:0]       r_mcnt;
    logic [IW-1:0]    r_home;
    logic [IW-1:0]    r_cur;
    logic [IW:0]      r_pcnt;
    logic [IW-1:0]    r_clr;
    logic [IW:0]      r_used;
    logic [31:0]      r_total;
    logic [31:0]      r_stamp;
    logic [IW-1:0]    r_scan_addr;
    logic [IW:0]      r_scan_left;
    logic             r_sd_vld;
    logic             r_sd_first;
    logic             r_sd_last;
    logic [IW-1:0]    r_sd_idx;
    logic             r_scan_done;
    logic [IW-1:0]    r_best;
    logic [31:0]      r_best_cnt;
    logic [31:0]      r_best_age;
    logic             r_ovld;
    logic [OUT_W-1:0] r_odata;

    logic [TAG_BITS-1:0]  w_tag;
    logic [NODE_BITS-1:0] w_a, w_b, w_c;
    logic [31:0]          w_hash;
    logic [IW:0]          w_rem_sh;
    logic [IW-1:0]        w_home;
    logic                 w_q_valid;
    logic [KW-1:0]        w_q_key;
    logic [31:0]          w_q_cnt, w_q_stamp, w_age;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    logic [MW-1:0]        w_wr_data;
    logic [31:0]          w_inc, w_cnt_new, w_total_new, w_total_add, w_value;
    logic [32:0]          w_sum_cnt, w_sum_tot;
    logic [IW:0]          w_used_new;
    logic [31:0]          w_stamp_new;
    logic [1:0]           w_status;
    logic                 w_scan_issue;

    assign w_tag = TAG_BITS'(i_tdata[9:2]);
    assign w_a   = NODE_BITS'(i_tdata[25:10]);
    assign w_b   = NODE_BITS'(i_tdata[41:26]);
    assign w_c   = NODE_BITS'(i_tdata[57:42]);
    assign w_hash = 32'(w_a) * 32'd31 + 32'(w_b) * 32'd17 + 32'(w_c) * 32'd7 + 32'(w_tag);

    assign w_rem_sh = {r_rem, r_h[31]};
    assign w_home   = IS_POW2 ? r_h[IW-1:0] : r_rem;

    assign w_q_valid = r_q[MW-1];
    assign w_q_key   = r_q[MW-2 -: KW];
    assign w_q_cnt   = r_q[63:32];
    assign w_q_stamp = r_q[31:0];
    assign w_age     = r_stamp - w_q_stamp;

    assign w_scan_issue = i_cmd.scan_run && (r_scan_left != '0);
    assign w_rd_en      = i_cmd.probe_rd || w_scan_issue;
    assign w_rd_addr    = i_cmd.probe_rd ? r_cur : r_scan_addr;

    // count, total, occupancy, stamp and status updates and slot memory write select
    always_comb begin
        w_inc = (r_func == FUNC_RECORD) ? 32'd1 : r_amt;
        w_sum_cnt = {1'b0, w_q_cnt} + {1'b0, w_inc};
        w_sum_tot = {1'b0, r_total} + {1'b0, w_inc};
        w_total_add = w_sum_tot[32] ? 32'hFFFF_FFFF : w_sum_tot[31:0];
        w_cnt_new = w_inc;
        w_total_new = r_total;
        w_used_new  = r_used;
        w_stamp_new = r_stamp;
        w_status    = STAT_OK;
        w_value     = 32'd0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cur;
        case (i_cmd.kind)
            KIND_HIT: begin
                w_cnt_new = w_sum_cnt[32] ? 32'hFFFF_FFFF : w_sum_cnt[31:0];
                w_value   = w_cnt_new;
                w_wr_en   = 1'b1;
                if (r_func == FUNC_RECORD) begin
                    w_total_new = w_total_add;
                end
            end
            KIND_FOUND: begin
                w_value = w_q_cnt;
            end
            KIND_FILL: begin
                w_value     = w_inc;
                w_wr_en     = 1'b1;
                w_used_new  = r_used + 1'b1;
                w_total_new = w_total_add;
                if (r_func == FUNC_RECORD) begin
                    w_stamp_new = r_stamp + 32'd1;
                end
            end
            KIND_EVICT: begin
                w_cnt_new   = 32'd1;
                w_value     = 32'd1;
                w_wr_en     = 1'b1;
                w_wr_addr   = r_best;
                w_total_new = w_total_add;
                w_stamp_new = r_stamp + 32'd1;
            end
            KIND_FULL: begin
                w_status = STAT_FULL;
            end
            default: begin
                w_status = STAT_MISS;
            end
        endcase
        w_wr_data = {1'b1, r_key, w_cnt_new, r_stamp};
        if (!i_cmd.commit) begin
            w_wr_en = 1'b0;
        end
        if (i_cmd.clr_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_q <= mem[w_rd_addr];
        end
    end

    // request, hash reduction, probe, scan, victim choice and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_tdata[1:0]);
            r_key  <= {w_tag, w_a, w_b, w_c};
            r_amt  <= i_tdata[89:58];
            r_h    <= w_hash;
            r_rem  <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mod_step && r_mcnt != 6'd32) begin
            r_h    <= r_h << 1;
            r_mcnt <= r_mcnt + 6'd1;
            if (w_rem_sh >= (IW+1)'(CAPACITY)) begin
                r_rem <= IW'(w_rem_sh - (IW+1)'(CAPACITY));
            end else begin
                r_rem <= IW'(w_rem_sh);
            end
        end
        if (i_cmd.probe_init) begin
            r_home <= w_home;
            r_cur  <= w_home;
            r_pcnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_cur  <= (r_cur == IW'(CAPACITY - 1)) ? '0 : r_cur + 1'b1;
            r_pcnt <= r_pcnt + 1'b1;
        end
        if (i_cmd.scan_begin) begin
            r_scan_addr <= r_home;
            r_scan_left <= (IW+1)'(CAPACITY);
        end else if (w_scan_issue) begin
            r_scan_addr <= (r_scan_addr == IW'(CAPACITY - 1)) ? '0 : r_scan_addr + 1'b1;
            r_scan_left <= r_scan_left - 1'b1;
        end
        r_sd_idx <= r_scan_addr;
        if (r_sd_vld && (r_sd_first || w_q_cnt < r_best_cnt ||
            (w_q_cnt == r_best_cnt && w_age > r_best_age))) begin
            r_best     <= r_sd_idx;
            r_best_cnt <= w_q_cnt;
            r_best_age <= w_age;
        end
        if (i_cmd.commit) begin
            r_odata <= {5'd0, w_total_new, 9'(w_used_new), w_value, w_status};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_stamp     <= '0;
            r_sd_vld    <= 1'b0;
            r_sd_first  <= 1'b0;
            r_sd_last   <= 1'b0;
            r_scan_done <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_used  <= w_used_new;
                r_total <= w_total_new;
                r_stamp <= w_stamp_new;
            end
            r_sd_vld   <= w_scan_issue;
            r_sd_first <= w_scan_issue && (r_scan_left == (IW+1)'(CAPACITY));
            r_sd_last  <= w_scan_issue && (r_scan_left == (IW+1)'(1));
            if (i_cmd.scan_begin) begin
                r_scan_done <= 1'b0;
            end else if (r_sd_last) begin
                r_scan_done <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.mod_done   = IS_POW2 || (r_mcnt == 6'd32);
        o_sts.q_hit      = w_q_valid && (w_q_key == r_key);
        o_sts.q_empty    = !w_q_valid;
        o_sts.probe_last = (r_pcnt == (IW+1)'(CAPACITY - 1));
        o_sts.scan_done  = r_scan_done;
        o_sts.clr_last   = (r_clr == IW'(CAPACITY - 1));
        o_sts.out_free   = !r_ovld || i_out_ready;
        o_sts.func       = r_func;
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (IW+1)'(CAPACITY))
        else $error("occupied slot count above capacity");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_ovld)
        else $error("result not presented after commit");
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("running total decreased");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_ovld || i_out_ready))
        else $error("result register overwritten");
`endif

endmodule

// ===== rtl/core/triplet_frequency_hash_table.sv =====
// top level of the triplet frequency hash table
//
// counts occurrences of (tag, a, b, c) keys in an open addressed table of CAPACITY slots
// input stream: one transaction per request (record, add, lookup); output stream: one
// transaction per request with status, count, occupied slots and running total
// after reset the slot memory is cleared one slot per cycle, every slot in turn, with
// s_axis_tready low until the clear is done
// each request passes through an accept step, a hash reduction when CAPACITY is not
// a power of two (none otherwise), a read and a check per probed slot through the
// registered memory read port, and a commit
// a record that finds the table full scans every slot for the victim
// one request is in flight at a time; a finished result waits in the output register,
// and the next request is taken while it waits
// when m_axis_tready stays low the block holds its next result until the register frees
module triplet_frequency_hash_table
    import tfht_pkg::*;
#(
    parameter int unsigned CAPACITY  = 256,
    parameter int unsigned NODE_BITS = 16,
    parameter int unsigned TAG_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,  // func, topo_tag, node_a, node_b, node_c, add_amount
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata   // status, count_value, entries_used, total_seen
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_accept;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    tfht_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_func   (t_func'(i_s_axis_tdata[1:0])),
        .i_sts    (w_sts),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (w_cmd)
    );

    tfht_dp #(
        .CAPACITY  (CAPACITY),
        .NODE_BITS (NODE_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tdata     (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// ===== test/triplet_frequency_hash_table_tb.sv =====
// testbench for the triplet frequency hash table: directed table, random traffic, self check
`timescale 1ns / 100ps

module triplet_frequency_hash_table_tb;
    import tfht_pkg::*;

    localparam int unsigned SLOTS      = 256;
    localparam int unsigned RAND_ITEMS = 750;
    localparam int unsigned QUIET_FROM = 650;
    localparam int unsigned IDLE_LIMIT = 5000;
    localparam logic [31:0] SAT        = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_key;

    typedef struct packed {
        logic [31:0] total;
        logic [8:0]  used;
        logic [31:0] count;
        logic [1:0]  status;
    } t_res;

    typedef struct {
        t_func       func;
        t_key        key;
        logic [31:0] amount;
        bit          typed;
        t_res        res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;  // func, topo_tag, node_a, node_b, node_c, add_amount
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b1;
    logic [OUT_W-1:0] o_m_axis_tdata;  // status, count_value, entries_used, total_seen

    triplet_frequency_hash_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // table shadow
    t_key        tbl_key   [SLOTS];
    logic [31:0] tbl_count [SLOTS];
    logic [31:0] tbl_stamp [SLOTS];
    bit          tbl_valid [SLOTS];
    logic [8:0]  tbl_used = '0;
    logic [31:0] tbl_total = '0;
    logic [31:0] tbl_stamp_now = '0;

    t_res pending_results[$];
    t_key key_pool[$];
    t_row rows[$];
    bit   quiet;
    bit   failed = 1'b0;
    int   idle_cycles = 0;
    int   rdy_hold = 0;
    int   row_idx = 0;

    function automatic logic [31:0] sat_sum(logic [31:0] x, logic [31:0] y);
        logic [32:0] s;
        s = x + y;
        return s[32] ? SAT : s[31:0];
    endfunction

    function automatic int home_of(t_key k);
        logic [31:0] h;
        h = 32'(k.a) * 31 + 32'(k.b) * 17 + 32'(k.c) * 7 + 32'(k.tag);
        return int'(h % SLOTS);
    endfunction

    // returns slot index or -1 when full without match
    function automatic int find_slot(t_key k, output bit hit);
        int h;
        int cur;
        h = home_of(k);
        hit = 0;
        for (int i = 0; i < SLOTS; i++) begin
            cur = (h + i) % SLOTS;
            if (!tbl_valid[cur]) return cur;
            if (tbl_key[cur] == k) begin
                hit = 1;
                return cur;
            end
        end
        return -1;
    endfunction

    function automatic int pick_evict(t_key k);
        int          h;
        int          cur;
        int          best;
        logic [31:0] best_cnt;
        logic [31:0] best_age;
        logic [31:0] age;
        h = home_of(k);
        best = h;
        best_cnt = tbl_count[h];
        best_age = tbl_stamp_now - tbl_stamp[h];
        for (int i = 1; i < SLOTS; i++) begin
            cur = (h + i) % SLOTS;
            age = tbl_stamp_now - tbl_stamp[cur];
            if (tbl_count[cur] < best_cnt || (tbl_count[cur] == best_cnt && age > best_age)) begin
                best = cur;
                best_cnt = tbl_count[cur];
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic t_res count_update(t_func f, t_key k, logic [31:0] amount);
        t_res r;
        bit   hit;
        int   s;
        int   t;
        r.status = STAT_MISS;
        r.count = '0;
        case (f)
            FUNC_RECORD: begin
                s = find_slot(k, hit);
                r.status = STAT_OK;
                if (hit) begin
                    tbl_count[s] = sat_sum(tbl_count[s], 32'd1);
                    tbl_stamp[s] = tbl_stamp_now;
                    r.count = tbl_count[s];
                end else begin
                    if (s >= 0) begin
                        t = s;
                        tbl_used++;
                    end else begin
                        t = pick_evict(k);
                    end
                    tbl_key[t] = k;
                    tbl_count[t] = 32'd1;
                    tbl_stamp[t] = tbl_stamp_now;
                    tbl_valid[t] = 1;
                    tbl_stamp_now++;
                    r.count = 32'd1;
                end
                tbl_total = sat_sum(tbl_total, 32'd1);
            end
            FUNC_ADD: begin
                s = find_slot(k, hit);
                if (hit) begin
                    tbl_count[s] = sat_sum(tbl_count[s], amount);
                    tbl_stamp[s] = tbl_stamp_now;
                    r.count = tbl_count[s];
                    r.status = STAT_OK;
                end else if (s >= 0) begin
                    tbl_key[s] = k;
                    tbl_count[s] = amount;
                    tbl_stamp[s] = tbl_stamp_now;
                    tbl_valid[s] = 1;
                    tbl_used++;
                    tbl_total = sat_sum(tbl_total, amount);
                    r.count = amount;
                    r.status = STAT_OK;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            FUNC_LOOKUP: begin
                s = find_slot(k, hit);
                if (hit) begin
                    r.status = STAT_OK;
                    r.count = tbl_count[s];
                end
            end
            default: ;
        endcase
        r.used = tbl_used;
        r.total = tbl_total;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_req(t_func f, t_key k, logic [31:0] amount);
        return {6'd0, amount, k.c, k.b, k.a, k.tag, f};
    endfunction

    function automatic t_key rand_key();
        t_key k;
        k.tag = 8'($urandom);
        k.a = 16'($urandom);
        k.b = 16'($urandom);
        k.c = 16'($urandom);
        return k;
    endfunction

    function automatic t_key mk_key(int tag, int a, int b, int c);
        t_key k;
        k.tag = tag[7:0];
        k.a = a[15:0];
        k.b = b[15:0];
        k.c = c[15:0];
        return k;
    endfunction

    function automatic t_res mk_res(logic [1:0] st, logic [31:0] cnt, int used,
                                    logic [31:0] tot);
        t_res r;
        r.status = st;
        r.count = cnt;
        r.used = used[8:0];
        r.total = tot;
        return r;
    endfunction

    function automatic t_row mk_row(t_func f, t_key k, logic [31:0] amount, bit typed,
                                    t_res r);
        t_row w;
        w.func = f;
        w.key = k;
        w.amount = amount;
        w.typed = typed;
        w.res = r;
        return w;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = 1'b1;
            #10 i_clk = 1'b0;
        end
    end

    // handshake monitor, predictor and checker
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        t_func f;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_res'(o_m_axis_tdata[74:0]);
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    failed = 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                    if (got.count !== want.count)
                        $display("%0t: count_value expected %h actual %h", $time,
                                 want.count, got.count);
                    if (got.used !== want.used)
                        $display("%0t: entries_used expected %0d actual %0d", $time,
                                 want.used, got.used);
                    if (got.total !== want.total)
                        $display("%0t: total_seen expected %h actual %h", $time,
                                 want.total, got.total);
                    if (got !== want) failed = 1;
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                f = t_func'(i_s_axis_tdata[1:0]);
                want = count_update(f, t_key'({i_s_axis_tdata[9:2], i_s_axis_tdata[25:10],
                                    i_s_axis_tdata[41:26], i_s_axis_tdata[57:42]}),
                                    i_s_axis_tdata[89:58]);
                if (row_idx < rows.size()) begin
                    if (rows[row_idx].typed) want = rows[row_idx].res;
                    row_idx = row_idx + 1;
                end
                pending_results.push_back(want);
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_m_axis_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= ~i_m_axis_tready;
            rdy_hold <= $urandom_range(0, 3);
        end
    end

    task automatic send_req(t_func f, t_key k, logic [31:0] amount);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = pack_req(f, k, amount);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        t_key        k;
        t_func       f;
        logic [31:0] amount;
        int          sel;
        quiet = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        rows.push_back(mk_row(FUNC_LOOKUP, mk_key(0, 0, 0, 0), 0, 1,
                              mk_res(STAT_MISS, 0, 0, 0)));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(0, 0, 0, 0), 0, 1,
                              mk_res(STAT_OK, 1, 1, 1)));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(0, 0, 0, 0), 0, 1,
                              mk_res(STAT_OK, 2, 1, 2)));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(255, 65535, 65535, 65535), 0, 1,
                              mk_res(STAT_OK, 1, 2, 3)));
        rows.push_back(mk_row(FUNC_LOOKUP, mk_key(255, 65535, 65535, 65535), 0, 1,
                              mk_res(STAT_OK, 1, 2, 3)));
        rows.push_back(mk_row(FUNC_NONE, mk_key(255, 65535, 65535, 65535), SAT, 1,
                              mk_res(STAT_MISS, 0, 2, 3)));
        rows.push_back(mk_row(FUNC_ADD, mk_key(5, 1, 2, 3), 5, 1,
                              mk_res(STAT_OK, 5, 3, 8)));
        rows.push_back(mk_row(FUNC_ADD, mk_key(5, 1, 2, 3), SAT, 1,
                              mk_res(STAT_OK, SAT, 3, 8)));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(5, 1, 2, 3), 0, 1,
                              mk_res(STAT_OK, SAT, 3, 9)));
        rows.push_back(mk_row(FUNC_ADD, mk_key(1, 7, 7, 7), 0, 1,
                              mk_res(STAT_OK, 0, 4, 9)));
        rows.push_back(mk_row(FUNC_LOOKUP, mk_key(9, 9, 9, 9), 0, 1,
                              mk_res(STAT_MISS, 0, 4, 9)));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(1, 7, 7, 7), 0, 1,
                              mk_res(STAT_OK, 1, 4, 10)));
        // colliding home slots, probe chain past occupied slots
        rows.push_back(mk_row(FUNC_RECORD, mk_key(7, 0, 0, 1), 0, 0, '0));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(14, 0, 0, 0), 0, 0, '0));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(0, 0, 0, 2), 0, 0, '0));
        rows.push_back(mk_row(FUNC_LOOKUP, mk_key(0, 0, 0, 2), 0, 0, '0));
        rows.push_back(mk_row(FUNC_LOOKUP, mk_key(21, 0, 0, 0), 0, 0, '0));
        rows.push_back(mk_row(FUNC_RECORD, mk_key(170, 43690, 21845, 43690), 0, 0, '0));
        rows.push_back(mk_row(FUNC_ADD, mk_key(85, 21845, 43690, 21845), 32'hAAAA_5555, 0,
                              '0));
        for (int i = 0; i < rows.size(); i++) begin
            key_pool.push_back(rows[i].key);
            send_req(rows[i].func, rows[i].key, rows[i].amount);
        end

        for (int n = 0; n < RAND_ITEMS + 10; n++) begin
            if (n >= QUIET_FROM) quiet = 1;
            sel = $urandom_range(0, 99);
            if (n >= RAND_ITEMS) begin
                // drive the running total into saturation
                f = FUNC_ADD;
                sel = 0;
            end else if (sel < 60) f = FUNC_RECORD;
            else if (sel < 75) f = FUNC_ADD;
            else if (sel < 95) f = FUNC_LOOKUP;
            else f = FUNC_NONE;
            if (($urandom_range(0, 99) < ((n < 400) ? 80 : 30)) || key_pool.size() == 0)
                k = rand_key();
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            key_pool.push_back(k);
            if (n >= RAND_ITEMS) amount = SAT;
            else if ($urandom_range(0, 49) == 0) amount = $urandom;
            else amount = $urandom_range(0, 1000);
            send_req(f, k, amount);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
